// ----- rtl/urs_pkg.sv -----
// Shared constants, register codes and word types of the ultrasonic ranging sequencer.
package urs_pkg;

  // Sizing of the sequencer.
  localparam int CHANNELS   = 3;
  localparam int TIMER_BITS = 18;
  localparam int DIST_BITS  = 16;

  // Derived widths and limits.
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW       = (TIMER_BITS > 18) ? TIMER_BITS : 18;
  localparam int DIST_LIM = (DIST_BITS < 16) ? ((1 << DIST_BITS) - 1) : 65535;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TRIGGER      = 3'd0,
    CFG_TIMEOUT      = 3'd1,
    CFG_SCALE        = 3'd2,
    CFG_OFFSET_LEFT  = 3'd3,
    CFG_OFFSET_FRONT = 3'd4,
    CFG_OFFSET_RIGHT = 3'd5
  } cfg_reg_t;

  // Sequencer phases, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  // Configuration bundle handed to the controller.
  typedef struct packed {
    logic [15:0] trigger_ticks;
    logic [17:0] timeout_ticks;
    logic [15:0] scale_recip;
    logic [9:0]  offset_left_mm;
    logic [9:0]  offset_front_mm;
    logic [9:0]  offset_right_mm;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  trigger_lines;
    logic        result_valid;
    logic [1:0]  result_channel;
    logic [15:0] distance_mm;
    logic        timed_out;
    logic        busy_res;
  } res_t;

endpackage

// ----- rtl/urs_dist.sv -----
// Echo width to distance conversion: scale, add mounting offset, saturate.
module urs_dist (
  input  logic [urs_pkg::TIMER_BITS-1:0] echo_count,
  input  logic [15:0]                    scale_recip,
  input  logic [9:0]                     offset_mm,
  output logic [15:0]                    distance_mm
);

  localparam int PW = urs_pkg::TIMER_BITS + 16;
  localparam int SW = urs_pkg::TIMER_BITS + 1;

  logic [PW-1:0] prod;
  logic [SW-1:0] sum;

  // Q16 product truncated by the shift, then the offset.
  assign prod = PW'(echo_count) * PW'(scale_recip);
  assign sum  = SW'(prod[PW-1:16]) + SW'(offset_mm);

  // Clamp to the largest distance the result can carry.
  always_comb begin
    if (33'(sum) > 33'(urs_pkg::DIST_LIM)) begin
      distance_mm = 16'(urs_pkg::DIST_LIM);
    end else begin
      distance_mm = 16'(sum);
    end
  end

endmodule

// ----- rtl/urs_ctrl.sv -----
// Ranging controller: per-tick phase logic, counters and stored distances.
module urs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              start_req,
  input  logic [2:0]        echo_lines,
  input  urs_pkg::cfg_t     cfg,
  output urs_pkg::res_t     res
);

  localparam int CH_W = urs_pkg::CH_W;
  localparam int TB   = urs_pkg::TIMER_BITS;
  localparam int TW   = urs_pkg::TW;

  urs_pkg::phase_t   phase_r, phase_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [TB-1:0]     tcnt_r, tcnt_nxt;
  logic [TB-1:0]     ecnt_r, ecnt_nxt;
  logic              eprev_r, eprev_nxt;
  logic [15:0]       last_r [urs_pkg::CHANNELS];

  urs_pkg::phase_t   cur_phase;
  logic              echo_bit;
  logic [2:0]        trig_bit;
  logic [9:0]        offset_sel;
  logic [15:0]       meas_dist;
  logic              done;
  logic              meas_done;
  logic              tmo_hit;
  logic              last_ch;

  // Select the active channel's echo, trigger line and offset.
  always_comb begin
    echo_bit   = 1'b0;
    trig_bit   = 3'b000;
    offset_sel = 10'd0;
    if (32'(ch_r) == 0) begin
      echo_bit   = echo_lines[0];
      trig_bit   = 3'b001;
      offset_sel = cfg.offset_left_mm;
    end
    if (32'(ch_r) == 1 && urs_pkg::CHANNELS > 1) begin
      echo_bit   = echo_lines[1];
      trig_bit   = 3'b010;
      offset_sel = cfg.offset_front_mm;
    end
    if (32'(ch_r) == 2 && urs_pkg::CHANNELS > 2) begin
      echo_bit   = echo_lines[2];
      trig_bit   = 3'b100;
      offset_sel = cfg.offset_right_mm;
    end
  end

  urs_dist u_dist (
    .echo_count  (ecnt_r),
    .scale_recip (cfg.scale_recip),
    .offset_mm   (offset_sel),
    .distance_mm (meas_dist)
  );

  assign last_ch = (32'(ch_r) == urs_pkg::CHANNELS - 1);

  // Next state and the result word for the tick in the input register.
  always_comb begin
    cur_phase = phase_r;
    if (phase_r == urs_pkg::PH_IDLE && start_req) begin
      cur_phase = urs_pkg::PH_TRIG;
    end

    phase_nxt = cur_phase;
    ch_nxt    = ch_r;
    tcnt_nxt  = tcnt_r;
    ecnt_nxt  = ecnt_r;
    eprev_nxt = eprev_r;
    meas_done = 1'b0;
    tmo_hit   = 1'b0;
    done      = 1'b0;
    res       = '0;

    if (cur_phase != urs_pkg::PH_IDLE) begin
      res.busy_res = 1'b1;
      if (tcnt_r != urs_pkg::TIMER_MAX) begin
        tcnt_nxt = tcnt_r + TB'(1);
      end

      case (cur_phase)
        urs_pkg::PH_TRIG: begin
          res.trigger_lines = trig_bit;
          if (TW'(tcnt_nxt) >= TW'(cfg.trigger_ticks)) begin
            phase_nxt = urs_pkg::PH_WAIT;
          end
        end
        urs_pkg::PH_WAIT: begin
          if (echo_bit && !eprev_r) begin
            phase_nxt = urs_pkg::PH_MEAS;
            ecnt_nxt  = TB'(1);
          end
        end
        urs_pkg::PH_MEAS: begin
          if (echo_bit) begin
            if (ecnt_r != urs_pkg::TIMER_MAX) begin
              ecnt_nxt = ecnt_r + TB'(1);
            end
          end else begin
            meas_done = 1'b1;
          end
        end
        default: begin
          phase_nxt = urs_pkg::PH_IDLE;
        end
      endcase
      eprev_nxt = echo_bit;

      // The timeout limit is clamped to the counter's ceiling.
      tmo_hit = !meas_done &&
                ((TW'(tcnt_nxt) >= TW'(cfg.timeout_ticks)) ||
                 (tcnt_nxt == urs_pkg::TIMER_MAX));
      done = meas_done || tmo_hit;

      if (done) begin
        res.result_valid   = 1'b1;
        res.result_channel = 2'(ch_r);
        res.timed_out      = tmo_hit;
        res.distance_mm    = meas_done ? meas_dist : last_r[ch_r];
        tcnt_nxt  = '0;
        ecnt_nxt  = '0;
        eprev_nxt = 1'b0;
        if (last_ch) begin
          phase_nxt = urs_pkg::PH_IDLE;
          ch_nxt    = '0;
        end else begin
          phase_nxt = urs_pkg::PH_TRIG;
          ch_nxt    = ch_r + CH_W'(1);
        end
      end
    end
  end

  // State registers advance once per processed tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urs_pkg::PH_IDLE;
      ch_r    <= '0;
      tcnt_r  <= '0;
      ecnt_r  <= '0;
      eprev_r <= 1'b0;
      for (int i = 0; i < urs_pkg::CHANNELS; i++) begin
        last_r[i] <= '0;
      end
    end else if (fire) begin
      phase_r <= phase_nxt;
      ch_r    <= ch_nxt;
      tcnt_r  <= tcnt_nxt;
      ecnt_r  <= ecnt_nxt;
      eprev_r <= eprev_nxt;
      if (meas_done) begin
        last_r[ch_r] <= meas_dist;
      end
    end
  end

endmodule

// ----- rtl/ultrasonic_ranging_sequencer.sv -----
// Top level: configuration registers, input register, controller and result register.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | start_req, echo_lines
//   out_    | output    | out_valid/out_ready | trigger_lines .. busy_res
//   cfg_    | input     | cfg_we              | cfg_idx, cfg_wdata
//
// Every input word (one time-base tick) yields exactly one result word.
// A word moves from the input register to the result register when it is processed,
// which a stalled result can delay; one word is accepted per cycle while the result
// register is free or being drained.
// Reset is synchronous and returns the sequencer to idle with stored distances
// cleared. A stalled result holds the pipeline; the input register still
// accepts one word while the result waits.
module ultrasonic_ranging_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_req,
  input  logic [2:0]  in_echo_lines,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_trigger_lines,
  output logic        out_result_valid,
  output logic [1:0]  out_result_channel,
  output logic [15:0] out_distance_mm,
  output logic        out_timed_out,
  output logic        out_busy_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [17:0] cfg_wdata
);

  urs_pkg::cfg_t cfg_r;
  logic          in_vld_r;
  logic          in_start_r;
  logic [2:0]    in_echo_r;
  logic          out_vld_r;
  urs_pkg::res_t res_r;
  urs_pkg::res_t res;
  logic          fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks   <= 16'd1000;
      cfg_r.timeout_ticks   <= 18'd200000;
      cfg_r.scale_recip     <= 16'd11299;
      cfg_r.offset_left_mm  <= 10'd140;
      cfg_r.offset_front_mm <= 10'd180;
      cfg_r.offset_right_mm <= 10'd140;
    end else if (cfg_we) begin
      case (cfg_idx)
        urs_pkg::CFG_TRIGGER:      cfg_r.trigger_ticks   <= cfg_wdata[15:0];
        urs_pkg::CFG_TIMEOUT:      cfg_r.timeout_ticks   <= cfg_wdata;
        urs_pkg::CFG_SCALE:        cfg_r.scale_recip     <= cfg_wdata[15:0];
        urs_pkg::CFG_OFFSET_LEFT:  cfg_r.offset_left_mm  <= cfg_wdata[9:0];
        urs_pkg::CFG_OFFSET_FRONT: cfg_r.offset_front_mm <= cfg_wdata[9:0];
        urs_pkg::CFG_OFFSET_RIGHT: cfg_r.offset_right_mm <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  // A tick is processed when the result register is free or being drained.
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_start_r <= in_start_req;
      in_echo_r  <= in_echo_lines;
    end
  end

  urs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .start_req  (in_start_r),
    .echo_lines (in_echo_r),
    .cfg        (cfg_r),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_trigger_lines  = res_r.trigger_lines;
  assign out_result_valid   = res_r.result_valid;
  assign out_result_channel = res_r.result_channel;
  assign out_distance_mm    = res_r.distance_mm;
  assign out_timed_out      = res_r.timed_out;
  assign out_busy_res       = res_r.busy_res;

endmodule

// ----- test/ultrasonic_ranging_sequencer_tb.sv -----
// Self-checking testbench of the ultrasonic ranging sequencer with a tick-level predictor.
module ultrasonic_ranging_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that decode to nothing.
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_TICKS = 450;
  localparam int unsigned PRESSURE_AT  = 60;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SHOW_MAX     = 100;

  // Predicts one result word per accepted tick and checks the words that come out.
  class ranging_scoreboard;
    urs_pkg::cfg_t                  regs;
    urs_pkg::phase_t                phase_now;
    int unsigned                    chan_now;
    logic [urs_pkg::TIMER_BITS-1:0] chan_ticks;
    logic [urs_pkg::TIMER_BITS-1:0] echo_ticks;
    logic                           echo_last;
    logic [15:0]                    stored_mm [urs_pkg::CHANNELS];
    urs_pkg::res_t                  expected_reports [$];
    int unsigned errors, checked, measured, timeouts, saturated, busy_ticks;

    function new();
      regs.trigger_ticks   = 16'd1000;
      regs.timeout_ticks   = 18'd200000;
      regs.scale_recip     = 16'd11299;
      regs.offset_left_mm  = 10'd140;
      regs.offset_front_mm = 10'd180;
      regs.offset_right_mm = 10'd140;
      phase_now  = urs_pkg::PH_IDLE;
      chan_now   = 0;
      chan_ticks = '0;
      echo_ticks = '0;
      echo_last  = 1'b0;
      foreach (stored_mm[i]) stored_mm[i] = '0;
    endfunction

    function void write_register(logic [2:0] idx, logic [17:0] data);
      case (idx)
        urs_pkg::CFG_TRIGGER:      regs.trigger_ticks   = data[15:0];
        urs_pkg::CFG_TIMEOUT:      regs.timeout_ticks   = data[17:0];
        urs_pkg::CFG_SCALE:        regs.scale_recip     = data[15:0];
        urs_pkg::CFG_OFFSET_LEFT:  regs.offset_left_mm  = data[9:0];
        urs_pkg::CFG_OFFSET_FRONT: regs.offset_front_mm = data[9:0];
        urs_pkg::CFG_OFFSET_RIGHT: regs.offset_right_mm = data[9:0];
        default: ;
      endcase
    endfunction

    function logic [9:0] offset_of(int unsigned ch);
      case (ch)
        0: return regs.offset_left_mm;
        1: return regs.offset_front_mm;
        2: return regs.offset_right_mm;
        default: return '0;
      endcase
    endfunction

    // Echo width in ticks scaled by the Q16 factor, plus the mounting offset, saturated.
    function logic [15:0] distance_of(int unsigned ch);
      logic [33:0] prod;
      logic [18:0] sum;
      prod = 34'(echo_ticks) * 34'(regs.scale_recip);
      sum  = 19'(prod[33:16]) + 19'(offset_of(ch));
      return (sum > urs_pkg::DIST_LIM) ? 16'(urs_pkg::DIST_LIM) : sum[15:0];
    endfunction

    function void open_channel(int unsigned ch);
      chan_now   = ch;
      phase_now  = urs_pkg::PH_TRIG;
      chan_ticks = '0;
      echo_ticks = '0;
      echo_last  = 1'b0;
    endfunction

    // Advance the sequencer by one tick and queue the word it must produce.
    function void predict_tick(logic start, logic [2:0] echo);
      urs_pkg::res_t                  r;
      int unsigned                    ch;
      logic                           level;
      logic                           done;
      logic [urs_pkg::TIMER_BITS-1:0] limit;
      r    = '0;
      done = 1'b0;
      if (phase_now == urs_pkg::PH_IDLE && start) open_channel(0);
      if (phase_now != urs_pkg::PH_IDLE) begin
        ch = (chan_now < urs_pkg::CHANNELS) ? chan_now : 0;
        level = (ch < 3) ? echo[ch] : 1'b0;
        r.busy_res = 1'b1;
        busy_ticks++;
        if (chan_ticks < urs_pkg::TIMER_MAX) chan_ticks++;
        case (phase_now)
          urs_pkg::PH_TRIG: begin
            if (ch < 3) r.trigger_lines = 3'(1 << ch);
            if (chan_ticks >= regs.trigger_ticks) phase_now = urs_pkg::PH_WAIT;
          end
          urs_pkg::PH_WAIT: begin
            if (level && !echo_last) begin
              phase_now  = urs_pkg::PH_MEAS;
              echo_ticks = urs_pkg::TIMER_BITS'(1);
            end
          end
          default: begin
            if (level) begin
              if (echo_ticks < urs_pkg::TIMER_MAX) echo_ticks++;
            end else begin
              stored_mm[ch]    = distance_of(ch);
              r.result_valid   = 1'b1;
              r.result_channel = 2'(ch);
              r.distance_mm    = stored_mm[ch];
              done             = 1'b1;
            end
          end
        endcase
        echo_last = level;
        // The limit register is as wide as the timer, so clamping is a no-op here.
        limit = (regs.timeout_ticks < urs_pkg::TIMER_MAX) ? regs.timeout_ticks
                                                          : urs_pkg::TIMER_MAX;
        if (!done && chan_ticks >= limit) begin
          r.result_valid   = 1'b1;
          r.result_channel = 2'(ch);
          r.distance_mm    = stored_mm[ch];
          r.timed_out      = 1'b1;
          done             = 1'b1;
        end
        if (done) begin
          if (ch + 1 < urs_pkg::CHANNELS) begin
            open_channel(ch + 1);
          end else begin
            phase_now  = urs_pkg::PH_IDLE;
            chan_now   = 0;
            chan_ticks = '0;
            echo_ticks = '0;
            echo_last  = 1'b0;
          end
        end
      end
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_report(urs_pkg::res_t got);
      urs_pkg::res_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: result word with nothing predicted, expected none, actual %h",
                   $time, got);
        return;
      end
      want = expected_reports.pop_front();
      checked++;
      compare_field("trigger_lines", want.trigger_lines, got.trigger_lines);
      compare_field("result_valid", want.result_valid, got.result_valid);
      compare_field("result_channel", want.result_channel, got.result_channel);
      compare_field("distance_mm", want.distance_mm, got.distance_mm);
      compare_field("timed_out", want.timed_out, got.timed_out);
      compare_field("busy_res", want.busy_res, got.busy_res);
      if (want.result_valid) begin
        if (want.timed_out) timeouts++;
        else measured++;
        if (!want.timed_out && want.distance_mm == 16'(urs_pkg::DIST_LIM)) saturated++;
      end
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void flag_missing();
      if (expected_reports.size() != 0) begin
        errors += expected_reports.size();
        $display("%0t: result words missing, expected %0d more, actual 0", $time,
                 expected_reports.size());
      end
    endfunction
  endclass

  // Echo shape that the sender produces on the active channel.
  typedef struct {
    int unsigned gap [3];
    int unsigned width [3];
    bit          hold_high;
    bit          noisy;
  } echo_plan_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        in_start_req  = 1'b0;
  logic [2:0]  in_echo_lines = 3'd0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [2:0]  out_trigger_lines;
  logic        out_result_valid;
  logic [1:0]  out_result_channel;
  logic [15:0] out_distance_mm;
  logic        out_timed_out;
  logic        out_busy_res;
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_idx       = 3'd0;
  logic [17:0] cfg_wdata     = 18'd0;

  ranging_scoreboard sb = new();
  echo_plan_t        plan;
  bit                quiet = 1'b0;
  int unsigned       wait_run = 0;
  int unsigned       ticks_sent = 0;
  int unsigned       settings = 0;

  ultrasonic_ranging_sequencer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_req      (in_start_req),
    .in_echo_lines     (in_echo_lines),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_lines (out_trigger_lines),
    .out_result_valid  (out_result_valid),
    .out_result_channel(out_result_channel),
    .out_distance_mm   (out_distance_mm),
    .out_timed_out     (out_timed_out),
    .out_busy_res      (out_busy_res),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls plus one long hold-off that backs up the input.
  initial begin
    int unsigned   stall;
    int unsigned   hold;
    bit            held;
    urs_pkg::res_t got;
    stall = 0;
    hold  = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.trigger_lines  = out_trigger_lines;
        got.result_valid   = out_result_valid;
        got.result_channel = out_result_channel;
        got.distance_mm    = out_distance_mm;
        got.timed_out      = out_timed_out;
        got.busy_res       = out_busy_res;
        sb.check_report(got);
      end
      if (!held && sb.checked >= PRESSURE_AT) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall != 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        out_ready <= (stall == 0);
        if (stall != 0) stall--;
      end
    end
  end

  // Offer one word and hold it until it is taken, then maybe idle.
  task automatic send_word(logic start, logic [2:0] echo);
    int unsigned gap;
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_echo_lines <= echo;
    do @(posedge clk); while (!in_ready);
    sb.predict_tick(start, echo);
    ticks_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Shape the active channel's echo from the predicted phase; other lines are noise.
  task automatic drive_tick(logic start);
    logic [2:0]  echo;
    int unsigned ch;
    logic        level;
    echo  = 3'($urandom_range(0, 7));
    ch    = (sb.phase_now == urs_pkg::PH_IDLE) ? 0 : sb.chan_now;
    level = echo[ch];
    case (sb.phase_now)
      urs_pkg::PH_IDLE: if (start) level = plan.hold_high;
      urs_pkg::PH_TRIG: level = plan.hold_high;
      urs_pkg::PH_WAIT: level = (wait_run >= plan.gap[ch]);
      default: level = (sb.echo_ticks < plan.width[ch]);
    endcase
    wait_run = (sb.phase_now == urs_pkg::PH_WAIT) ? wait_run + 1 : 0;
    if (plan.noisy && $urandom_range(0, 7) == 0) level = !level;
    echo[ch] = level;
    send_word(start, echo);
  endtask

  // A start request, then ticks with random start bits until all three channels have reported.
  task automatic range_sweep();
    drive_tick(1'b1);
    while (sb.phase_now != urs_pkg::PH_IDLE) drive_tick($urandom_range(0, 3) == 0);
  endtask

  // Stop offering and wait for every predicted word, plus a few cycles of slack.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  // Random bits above a register's width must be dropped by the block.
  function automatic logic [17:0] with_junk(logic [17:0] v, int unsigned w);
    return v | (18'($urandom) << w);
  endfunction

  task automatic configure(logic [15:0] trig, logic [17:0] tmo, logic [15:0] scale,
                           logic [9:0] off_l, logic [9:0] off_f, logic [9:0] off_r);
    write_reg(urs_pkg::CFG_TRIGGER, with_junk(18'(trig), 16));
    write_reg(urs_pkg::CFG_TIMEOUT, tmo);
    write_reg(urs_pkg::CFG_SCALE, with_junk(18'(scale), 16));
    write_reg(urs_pkg::CFG_OFFSET_LEFT, with_junk(18'(off_l), 10));
    write_reg(urs_pkg::CFG_OFFSET_FRONT, with_junk(18'(off_f), 10));
    write_reg(urs_pkg::CFG_OFFSET_RIGHT, with_junk(18'(off_r), 10));
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic void set_plan(int unsigned g0, int unsigned g1, int unsigned g2,
                                   int unsigned w0, int unsigned w1, int unsigned w2,
                                   bit hold_high);
    plan.gap[0]    = g0;
    plan.gap[1]    = g1;
    plan.gap[2]    = g2;
    plan.width[0]  = w0;
    plan.width[1]  = w1;
    plan.width[2]  = w2;
    plan.hold_high = hold_high;
    plan.noisy     = 1'b0;
  endfunction

  function automatic void random_plan();
    plan.hold_high = ($urandom_range(0, 3) == 0);
    plan.noisy     = ($urandom_range(0, 6) == 0);
    for (int i = 0; i < 3; i++) begin
      plan.gap[i]   = $urandom_range(0, 8);
      plan.width[i] = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 120)
                                                  : $urandom_range(1, 20);
    end
  endfunction

  // Short timeouts keep channels cheap; extremes show up often.
  task automatic random_config();
    logic [15:0] trig;
    logic [17:0] tmo;
    logic [15:0] scale;
    logic [9:0]  offs [3];
    case ($urandom_range(0, 9))
      0:       trig = 16'd0;
      1:       trig = 16'hFFFF;
      default: trig = 16'($urandom_range(1, 6));
    endcase
    if (trig == 16'hFFFF) begin
      tmo = 18'($urandom_range(0, 20));
    end else begin
      case ($urandom_range(0, 9))
        0:       tmo = 18'd0;
        1, 2:    tmo = 18'($urandom_range(61, 200));
        default: tmo = 18'($urandom_range(4, 60));
      endcase
    end
    case ($urandom_range(0, 6))
      0:       scale = 16'd0;
      1:       scale = 16'hFFFF;
      default: scale = 16'($urandom);
    endcase
    foreach (offs[i]) begin
      case ($urandom_range(0, 4))
        0:       offs[i] = 10'd0;
        1:       offs[i] = 10'd1023;
        default: offs[i] = 10'($urandom);
      endcase
    end
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_LO, 18'($urandom));
    configure(trig, tmo, scale, offs[0], offs[1], offs[2]);
  endtask

  // Give up if the run hangs.
  initial begin
    #20_000_000;
    $display("ultrasonic_ranging_sequencer regression: fail");
    $finish;
  end

  initial begin
    int unsigned mark;
    int unsigned sweeps;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Short trigger only; timeout, scale and offsets keep their reset values.
    write_reg(urs_pkg::CFG_TRIGGER, 18'd4);
    cfg_we <= 1'b0;
    quiet = 1'b1;
    set_plan(3, 5, 2, 10, 120, 1, 1'b0);
    range_sweep();
    drain();
    quiet = 1'b0;

    // Zero trigger width with the echo already high when the trigger ends.
    configure(16'd0, 18'd30, 16'hFFFF, 10'd1023, 10'd0, 10'd512);
    set_plan(1, 2, 1, 1, 5, 40, 1'b1);
    range_sweep();
    drain();

    // A timeout shorter than the trigger cuts the trigger short.
    configure(16'hFFFF, 18'd7, 16'd11299, 10'd140, 10'd180, 10'd140);
    set_plan(0, 0, 0, 1, 1, 1, 1'b0);
    range_sweep();
    drain();

    // Zero timeout: each channel gives up on its first tick.
    configure(16'd5, 18'd0, 16'd4000, 10'd300, 10'd301, 10'd302);
    range_sweep();
    drain();

    // Writes to unused indexes must leave every register alone; zero scale.
    write_reg(CFG_SPARE_LO, 18'($urandom));
    write_reg(CFG_SPARE_HI, '1);
    configure(16'd2, 18'd50, 16'd0, 10'd0, 10'd0, 10'd0);
    @(posedge clk);
    write_reg(CFG_SPARE_HI, 18'($urandom));
    write_reg(CFG_SPARE_LO, '1);
    cfg_we <= 1'b0;
    set_plan(2, 0, 4, 3, 1, 9, 1'b0);
    range_sweep();
    drain();

    // Full scale, widest timeout and largest offsets.
    quiet = 1'b1;
    configure(16'd1, 18'h3FFFF, 16'hFFFF, 10'd1023, 10'd1023, 10'd1023);
    set_plan(0, 1, 0, 40, 3, 3, 1'b0);
    range_sweep();
    drain();
    quiet = 1'b0;

    // Echo stuck high from the trigger on: no rising edge, so every channel times out.
    configure(16'd3, 18'd25, 16'd20000, 10'd10, 10'd20, 10'd30);
    set_plan(0, 0, 0, 5, 5, 5, 1'b1);
    range_sweep();
    drain();

    // Random sweeps with random echo shapes, new settings every few sweeps.
    mark   = sb.busy_ticks;
    sweeps = 0;
    while (sb.busy_ticks < mark + RANDOM_TICKS) begin
      if (sweeps % 3 == 0) begin
        drain();
        random_config();
      end
      quiet = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 3)) drive_tick(1'b0);
      random_plan();
      range_sweep();
      sweeps++;
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    sb.flag_missing();
    $display("Covered %0d ticks over %0d register settings: %0d words checked,",
             ticks_sent, settings, sb.checked);
    $display("%0d channels measured (%0d saturated) and %0d timed out.",
             sb.measured, sb.saturated, sb.timeouts);
    if (sb.errors == 0) begin
      $display("ultrasonic_ranging_sequencer regression: pass");
    end else begin
      $display("ultrasonic_ranging_sequencer regression: fail");
    end
    $finish;
  end

endmodule
